[rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/itvw_pkg.sv]
// shared types and constants of the vietnamese integer reader
// no dependencies
package itvw_pkg;

   localparam int DIGITS   = 19;   // decimal digits of the magnitude
   localparam int CHUNKS   = 7;    // three-digit groups, top one holds a single digit
   localparam int MAG_BITS = 63;   // magnitude bits after the sign is removed
   localparam int CODE_W   = 5;

   localparam logic [CODE_W-1:0] W_TEN      = 5'd10;
   localparam logic [CODE_W-1:0] W_TENS     = 5'd11;
   localparam logic [CODE_W-1:0] W_MOT      = 5'd12;
   localparam logic [CODE_W-1:0] W_TU       = 5'd13;
   localparam logic [CODE_W-1:0] W_LAM      = 5'd14;
   localparam logic [CODE_W-1:0] W_HUNDRED  = 5'd15;
   localparam logic [CODE_W-1:0] W_ODD      = 5'd16;
   localparam logic [CODE_W-1:0] W_THOUSAND = 5'd17;
   localparam logic [CODE_W-1:0] W_MILLION  = 5'd18;
   localparam logic [CODE_W-1:0] W_BILLION  = 5'd19;
   localparam logic [CODE_W-1:0] W_MINUS    = 5'd20;
   localparam logic [CODE_W-1:0] W_MAX      = W_MINUS;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CONV  = 4'b0010,
      ST_EMIT  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

endpackage

[rtl/integer_to_vietnamese_words.sv]
// vietnamese integer reader, top level
// depends on itvw_pkg
//
// Takes one signed 64-bit value when start is high and busy is low, and
// answers with its spoken vietnamese reading, one word code per strobe of
// rsp_valid, the final word marked by rsp_last_word. The receiver cannot
// stall, so words leave as they are made. An item runs from accept to the
// end of busy as follows: the sign comes off as the item is taken, then
// shift-and-add-3 turns the magnitude into decimal one bit per cycle, then
// a word sequencer walks the seven three-digit groups in eleven steps
// each, and a flush step sends the final word. Words come out spread over
// that walk, at most one per cycle, and the final word is on the port as
// busy falls. The most negative value is read as minus (2^63 - 1).
module integer_to_vietnamese_words
   import itvw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic signed [63:0] req_value,
   output logic              rsp_valid,
   output logic [CODE_W-1:0] rsp_word_code,
   output logic              rsp_last_word
);

   // steps of the sequencer inside one group
   localparam logic [3:0] SL_HUND_DIG = 4'd0;
   localparam logic [3:0] SL_HUND     = 4'd1;
   localparam logic [3:0] SL_ODD      = 4'd2;
   localparam logic [3:0] SL_TEN_DIG  = 4'd3;
   localparam logic [3:0] SL_TENS     = 4'd4;
   localparam logic [3:0] SL_UNIT     = 4'd5;
   localparam logic [3:0] SL_GROUP    = 4'd6;
   localparam logic [3:0] SL_BILLION  = 4'd7;
   localparam logic [3:0] SL_PAD_ZERO = 4'd8;
   localparam logic [3:0] SL_PAD_HUND = 4'd9;
   localparam logic [3:0] SL_PAD_ODD  = 4'd10;
   localparam logic [3:0] SL_END      = SL_PAD_ODD;

   localparam int BCD_W = 4 * DIGITS;
   localparam int PAD_W = 12 * CHUNKS;

   // group indexes, most significant first
   localparam logic [2:0] G_TOP   = 3'(CHUNKS - 1);
   localparam logic [2:0] G_MIL_H = 3'd5;
   localparam logic [2:0] G_THO_H = 3'd4;
   localparam logic [2:0] G_BIL_L = 3'd3;
   localparam logic [2:0] G_MIL_L = 3'd2;
   localparam logic [2:0] G_THO_L = 3'd1;
   localparam logic [2:0] G_UNITS = 3'd0;

   state_type             state_ff, state_in;
   logic [MAG_BITS-1:0]   bin_ff, bin_in;
   logic [5:0]            bit_cnt_ff, bit_cnt_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic [2:0]            chunk_ff, chunk_in;
   logic [3:0]            slot_ff, slot_in;
   logic [CODE_W-1:0]     hold_ff, hold_in;
   logic                  hold_vld_ff, hold_vld_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]     rsp_code_ff, rsp_code_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [63:0]           neg_val;
   logic [MAG_BITS-1:0]   mag;
   logic [BCD_W-1:0]      bcd_adj;
   logic [PAD_W-1:0]      pad_flat;
   logic [11:0]           chunk_val [CHUNKS];
   logic [CHUNKS-1:0]     nz;
   logic [11:0]           cur, low;
   logic [3:0]            h, t, u;
   logic [2:0]            lo_idx;
   logic                  upper_nz, cur_nz, grp_emit, is_thou, pad_en;
   logic [CODE_W-1:0]     grp_word, unit_word;
   logic                  gen_valid;
   logic [CODE_W-1:0]     gen_code;

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_word_code = rsp_code_ff;
   assign rsp_last_word = rsp_last_ff;

   // magnitude, with the most negative value clamped
   assign neg_val = ~req_value + 64'd1;
   always_comb begin
      if (!req_value[63]) begin
         mag = req_value[MAG_BITS-1:0];
      end else if (neg_val[63]) begin
         mag = '1;
      end else begin
         mag = neg_val[MAG_BITS-1:0];
      end
   end

   // add 3 to every decimal digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   // three-digit groups and their nonzero flags
   assign pad_flat = {{(PAD_W - BCD_W){1'b0}}, bcd_ff};
   always_comb begin
      for (int k = 0; k < CHUNKS; k++) begin
         chunk_val[k] = pad_flat[12*k +: 12];
         nz[k]        = |pad_flat[12*k +: 12];
      end
   end

   assign cur    = chunk_val[chunk_ff];
   assign h      = cur[11:8];
   assign t      = cur[7:4];
   assign u      = cur[3:0];
   assign cur_nz = nz[chunk_ff];

   // lowest group of the remainder that follows this group's word
   assign lo_idx = (chunk_ff >= G_THO_H) ? G_BIL_L : G_UNITS;
   assign low    = chunk_val[lo_idx];
   always_comb begin
      upper_nz = 1'b0;
      for (int i = 0; i < CHUNKS; i++) begin
         if (3'(i) > lo_idx && 3'(i) < chunk_ff && nz[i]) begin
            upper_nz = 1'b1;
         end
      end
   end

   always_comb begin
      unique case (chunk_ff)
         G_TOP, G_BIL_L: grp_word = W_BILLION;
         G_MIL_H, G_MIL_L: grp_word = W_MILLION;
         default: grp_word = W_THOUSAND;
      endcase
   end

   // the billion word after the low billion group stands whenever it or any group above it is nonzero
   always_comb begin
      if (chunk_ff == G_BIL_L) begin
         grp_emit = |nz[CHUNKS-1:G_BIL_L];
      end else begin
         grp_emit = cur_nz && (chunk_ff != G_UNITS);
      end
   end

   // "zero hundred (odd)" padding of a small remainder
   assign is_thou = (chunk_ff == G_THO_H) || (chunk_ff == G_THO_L);
   assign pad_en  = grp_emit && nz[lo_idx] && !upper_nz && (!is_thou || low[11:8] == 4'd0);

   // units word, with the spoken forms after a tens digit
   always_comb begin
      priority if (t == 4'd0) begin
         unit_word = {1'b0, u};
      end else if (u == 4'd1) begin
         unit_word = (t == 4'd1) ? {1'b0, u} : W_MOT;
      end else if (u == 4'd4) begin
         unit_word = (t == 4'd1) ? {1'b0, u} : W_TU;
      end else if (u == 4'd5) begin
         unit_word = W_LAM;
      end else begin
         unit_word = {1'b0, u};
      end
   end

   // word made at the current step, if any
   always_comb begin
      gen_valid = 1'b0;
      gen_code  = {1'b0, h};
      unique case (slot_ff)
         SL_HUND_DIG: begin
            gen_valid = cur_nz && h != 4'd0;
            gen_code  = {1'b0, h};
         end
         SL_HUND: begin
            gen_valid = cur_nz && h != 4'd0;
            gen_code  = W_HUNDRED;
         end
         SL_ODD: begin
            gen_valid = h != 4'd0 && t == 4'd0 && u != 4'd0;
            gen_code  = W_ODD;
         end
         SL_TEN_DIG: begin
            gen_valid = t != 4'd0;
            gen_code  = (t == 4'd1) ? W_TEN : {1'b0, t};
         end
         SL_TENS: begin
            gen_valid = t != 4'd0 && t != 4'd1;
            gen_code  = W_TENS;
         end
         SL_UNIT: begin
            // a zero value reads as the single word zero
            gen_valid = (u != 4'd0) || (chunk_ff == G_UNITS && nz == '0);
            gen_code  = unit_word;
         end
         SL_GROUP: begin
            gen_valid = grp_emit && chunk_ff != G_BIL_L;
            gen_code  = grp_word;
         end
         SL_BILLION: begin
            gen_valid = grp_emit && chunk_ff == G_BIL_L;
            gen_code  = W_BILLION;
         end
         SL_PAD_ZERO: begin
            gen_valid = pad_en;
            gen_code  = 5'd0;
         end
         SL_PAD_HUND: begin
            gen_valid = pad_en;
            gen_code  = W_HUNDRED;
         end
         SL_PAD_ODD: begin
            gen_valid = pad_en && low[11:4] == 8'd0;
            gen_code  = W_ODD;
         end
         default: begin
            gen_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      bit_cnt_in   = bit_cnt_ff;
      bcd_in       = bcd_ff;
      chunk_in     = chunk_ff;
      slot_in      = slot_ff;
      hold_in      = hold_ff;
      hold_vld_in  = hold_vld_ff;
      rsp_valid_in = 1'b0;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               bin_in      = mag;
               bcd_in      = '0;
               bit_cnt_in  = '0;
               chunk_in    = G_TOP;
               slot_in     = SL_HUND_DIG;
               // minus leads the reading of a negative value
               hold_in     = W_MINUS;
               hold_vld_in = req_value[63];
               state_in    = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in     = {bcd_adj[BCD_W-2:0], bin_ff[MAG_BITS-1]};
            bin_in     = {bin_ff[MAG_BITS-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 6'd1;
            if (bit_cnt_ff == 6'(MAG_BITS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // one word of lookahead tells which word is the last
            if (gen_valid) begin
               if (hold_vld_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_code_in  = hold_ff;
                  rsp_last_in  = 1'b0;
               end
               hold_in     = gen_code;
               hold_vld_in = 1'b1;
            end
            if (slot_ff == SL_END) begin
               slot_in = SL_HUND_DIG;
               if (chunk_ff == G_UNITS) begin
                  state_in = ST_FLUSH;
               end else begin
                  chunk_in = chunk_ff - 3'd1;
               end
            end else begin
               slot_in = slot_ff + 4'd1;
            end
         end
         ST_FLUSH: begin
            rsp_valid_in = 1'b1;
            rsp_code_in  = hold_ff;
            rsp_last_in  = 1'b1;
            hold_vld_in  = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hold_vld_ff  <= hold_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bit_cnt_ff  <= bit_cnt_in;
      bcd_ff      <= bcd_in;
      chunk_ff    <= chunk_in;
      slot_ff     <= slot_in;
      hold_ff     <= hold_in;
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

[rtl/itvw_checker.sv]
// port-level checks of the vietnamese integer reader, bound to the top level
// depends on itvw_pkg and assert_macros.svh
`include "assert_macros.svh"

module itvw_checker
   import itvw_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic signed [63:0] req_value,
   input logic              rsp_valid,
   input logic [CODE_W-1:0] rsp_word_code,
   input logic              rsp_last_word
);

   // an accepted item keeps the block busy
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // the conversion runs before any word of a new item
   `ASSERT_NEXT(a_no_word_after_accept, clock, reset, start && !busy, !rsp_valid)
   // the final word is never followed at once by another
   `ASSERT_NEXT(a_gap_after_last, clock, reset, rsp_valid && rsp_last_word, !rsp_valid)
   // only defined word codes leave the block
   `ASSERT_IMPL(a_code_range, clock, reset, rsp_valid, rsp_word_code <= W_MAX)

endmodule

bind integer_to_vietnamese_words itvw_checker u_itvw_checker (.*);
